[sv/pce_pkg.sv]
package pce_pkg;

    // Widths of the configuration fields and of the result field.
    localparam int REG_BITS   = 64;
    localparam int WIDTH_BITS = 7;
    localparam int INDEX_BITS = 3;

    // Narrowest CRC the engine supports.
    localparam logic [WIDTH_BITS-1:0] MIN_CRC_WIDTH = 7'd8;

    // Configuration register indexes.
    localparam logic [INDEX_BITS-1:0] CFG_CRC_WIDTH      = 3'd0;
    localparam logic [INDEX_BITS-1:0] CFG_POLYNOMIAL     = 3'd1;
    localparam logic [INDEX_BITS-1:0] CFG_INITIAL_VALUE  = 3'd2;
    localparam logic [INDEX_BITS-1:0] CFG_FINAL_XOR      = 3'd3;
    localparam logic [INDEX_BITS-1:0] CFG_REFLECT_INPUT  = 3'd4;
    localparam logic [INDEX_BITS-1:0] CFG_REFLECT_OUTPUT = 3'd5;

    // Reset values of the configuration registers (CRC-32).
    localparam logic [WIDTH_BITS-1:0] RST_CRC_WIDTH     = 7'd32;
    localparam logic [REG_BITS-1:0]   RST_POLYNOMIAL    = 64'h0000_0000_04C1_1DB7;
    localparam logic [REG_BITS-1:0]   RST_INITIAL_VALUE = 64'h0000_0000_FFFF_FFFF;
    localparam logic [REG_BITS-1:0]   RST_FINAL_XOR     = 64'h0000_0000_FFFF_FFFF;
    localparam logic                  RST_REFLECT_IN    = 1'b1;
    localparam logic                  RST_REFLECT_OUT   = 1'b1;

    // Configuration as seen by the datapath, already masked and prepared.
    typedef struct packed {
        logic [WIDTH_BITS-1:0] rev_shift;  // MAX_WIDTH minus the effective width
        logic                  refin;      // process bytes LSB first
        logic                  rev_out;    // reverse the remainder at the end
        logic [REG_BITS-1:0]   mask;       // ones over the effective width
        logic [REG_BITS-1:0]   top;        // single bit at width minus one
        logic [REG_BITS-1:0]   poly;       // normal polynomial, masked
        logic [REG_BITS-1:0]   rpoly;      // reflected polynomial over the width
        logic [REG_BITS-1:0]   init;       // start remainder, masked
        logic [REG_BITS-1:0]   fxor;       // final XOR, masked
    } pce_cfg_t;

endpackage

[sv/pce_cfg.sv]
module pce_cfg #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pce_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [pce_pkg::REG_BITS-1:0]  cfg_wdata,
    output pce_pkg::pce_cfg_t             cfg_out
);
    import pce_pkg::*;

    logic [WIDTH_BITS-1:0] width_reg, width_next;
    logic [REG_BITS-1:0]   poly_reg, poly_next;
    logic [REG_BITS-1:0]   init_reg, init_next;
    logic [REG_BITS-1:0]   fxor_reg, fxor_next;
    logic                  refin_reg, refin_next;
    logic                  refout_reg, refout_next;
    pce_cfg_t              prep_reg, prep_next;

    logic [WIDTH_BITS-1:0] eff_width;
    logic [WIDTH_BITS-1:0] shift;
    logic [MAX_WIDTH-1:0]  mask;
    logic [MAX_WIDTH-1:0]  poly_rev;

    // The write channel never stalls.
    assign cfg_ready = 1'b1;

    // Register file update, with the synchronous reset folded in.
    always_comb begin
        width_next  = width_reg;
        poly_next   = poly_reg;
        init_next   = init_reg;
        fxor_next   = fxor_reg;
        refin_next  = refin_reg;
        refout_next = refout_reg;
        if (!aresetn) begin
            width_next  = RST_CRC_WIDTH;
            poly_next   = RST_POLYNOMIAL;
            init_next   = RST_INITIAL_VALUE;
            fxor_next   = RST_FINAL_XOR;
            refin_next  = RST_REFLECT_IN;
            refout_next = RST_REFLECT_OUT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CRC_WIDTH:      width_next  = cfg_wdata[WIDTH_BITS-1:0];
                CFG_POLYNOMIAL:     poly_next   = cfg_wdata;
                CFG_INITIAL_VALUE:  init_next   = cfg_wdata;
                CFG_FINAL_XOR:      fxor_next   = cfg_wdata;
                CFG_REFLECT_INPUT:  refin_next  = cfg_wdata[0];
                CFG_REFLECT_OUTPUT: refout_next = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp the width into the supported range.
    always_comb begin
        if (width_next < MIN_CRC_WIDTH) begin
            eff_width = MIN_CRC_WIDTH;
        end else if (width_next > WIDTH_BITS'(MAX_WIDTH)) begin
            eff_width = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            eff_width = width_next;
        end
        shift = WIDTH_BITS'(MAX_WIDTH) - eff_width;
    end

    // Reverse the polynomial over the full width; the shift aligns it to the CRC width.
    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            poly_rev[i] = poly_next[MAX_WIDTH-1-i];
        end
    end

    assign mask = {MAX_WIDTH{1'b1}} >> shift;

    // Prepared values follow the registers so they are ready with them.
    always_comb begin
        prep_next.rev_shift = shift;
        prep_next.refin     = refin_next;
        prep_next.rev_out   = refin_next ^ refout_next;
        prep_next.mask      = REG_BITS'(mask);
        prep_next.top       = REG_BITS'(MAX_WIDTH'(1) << (eff_width - 7'd1));
        prep_next.poly      = REG_BITS'(poly_next[MAX_WIDTH-1:0] & mask);
        prep_next.rpoly     = REG_BITS'(poly_rev >> shift);
        prep_next.init      = REG_BITS'(init_next[MAX_WIDTH-1:0] & mask);
        prep_next.fxor      = REG_BITS'(fxor_next[MAX_WIDTH-1:0] & mask);
    end

    always_ff @(posedge aclk) begin
        width_reg  <= width_next;
        poly_reg   <= poly_next;
        init_reg   <= init_next;
        fxor_reg   <= fxor_next;
        refin_reg  <= refin_next;
        refout_reg <= refout_next;
        prep_reg   <= prep_next;
    end

    assign cfg_out = prep_reg;

endmodule

[sv/pce_fold.sv]
module pce_fold #(
    parameter int MAX_WIDTH = 64
) (
    input  pce_pkg::pce_cfg_t      cfg,
    input  logic [MAX_WIDTH-1:0]   rem_in,
    input  logic [7:0]             data_byte,
    input  logic                   byte_present,
    output logic [MAX_WIDTH-1:0]   rem_out,
    output logic [MAX_WIDTH-1:0]   crc_out
);
    import pce_pkg::*;

    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] top;
    logic [MAX_WIDTH-1:0] poly;
    logic [MAX_WIDTH-1:0] rpoly;
    logic [MAX_WIDTH-1:0] fxor;
    logic [MAX_WIDTH-1:0] rem_refl;
    logic [MAX_WIDTH-1:0] rem_norm;
    logic [MAX_WIDTH-1:0] rem_rev;
    logic [MAX_WIDTH-1:0] crc_sel;

    assign mask  = cfg.mask[MAX_WIDTH-1:0];
    assign top   = cfg.top[MAX_WIDTH-1:0];
    assign poly  = cfg.poly[MAX_WIDTH-1:0];
    assign rpoly = cfg.rpoly[MAX_WIDTH-1:0];
    assign fxor  = cfg.fxor[MAX_WIDTH-1:0];

    // Reflected form: the byte enters at the low end, eight right shifts.
    always_comb begin
        rem_refl = (rem_in & mask) ^ MAX_WIDTH'(data_byte);
        for (int k = 0; k < 8; k++) begin
            rem_refl = rem_refl[0] ? ((rem_refl >> 1) ^ rpoly) : (rem_refl >> 1);
        end
    end

    // Normal form: one message bit at the top for each of eight left shifts.
    always_comb begin
        rem_norm = rem_in & mask;
        for (int k = 0; k < 8; k++) begin
            if (data_byte[7-k]) begin
                rem_norm = rem_norm ^ top;
            end
            if ((rem_norm & top) != '0) begin
                rem_norm = (rem_norm << 1) ^ poly;
            end else begin
                rem_norm = rem_norm << 1;
            end
            rem_norm = rem_norm & mask;
        end
    end

    // Pick the updated remainder; an empty item leaves it as it was.
    always_comb begin
        if (!byte_present) begin
            rem_out = rem_in & mask;
        end else if (cfg.refin) begin
            rem_out = rem_refl & mask;
        end else begin
            rem_out = rem_norm;
        end
    end

    // Final value: optional reversal over the width, then the final XOR.
    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            rem_rev[i] = rem_out[MAX_WIDTH-1-i];
        end
        crc_sel = cfg.rev_out ? (rem_rev >> cfg.rev_shift) : rem_out;
        crc_out = (crc_sel ^ fxor) & mask;
    end

endmodule

[sv/pce_core.sv]
module pce_core #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pce_pkg::pce_cfg_t            cfg,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    input  logic                         s_tuser,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pce_pkg::REG_BITS-1:0] m_tdata
);
    import pce_pkg::*;

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_present_reg;
    logic                 in_last_reg;
    logic                 idle_reg, idle_next;
    logic [MAX_WIDTH-1:0] rem_reg, rem_next;
    logic                 out_valid_reg, out_valid_next;
    logic [REG_BITS-1:0]  out_data_reg;

    logic                 advance;
    logic                 in_xfer;
    logic [MAX_WIDTH-1:0] rem_src;
    logic [MAX_WIDTH-1:0] rem_fold;
    logic [MAX_WIDTH-1:0] crc_fold;

    // An item in the input register moves on unless its result has nowhere to go.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    // The first item of a message starts from the initial value.
    assign rem_src = idle_reg ? cfg.init[MAX_WIDTH-1:0] : rem_reg;

    pce_fold #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_fold (
        .cfg          (cfg),
        .rem_in       (rem_src),
        .data_byte    (in_byte_reg),
        .byte_present (in_present_reg),
        .rem_out      (rem_fold),
        .crc_out      (crc_fold)
    );

    // Control next state.
    always_comb begin
        in_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        idle_next      = advance ? in_last_reg : idle_reg;
        rem_next       = advance ? rem_fold : rem_reg;
        out_valid_next = (advance && in_last_reg) ? 1'b1
                       : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            idle_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input item, running remainder, finished CRC.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
        rem_reg <= rem_next;
        if (advance && in_last_reg) begin
            out_data_reg <= REG_BITS'(crc_fold);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/parameterized_crc_engine_top.sv]
// Generic CRC engine (Rocksoft model) for widths of 8 to MAX_WIDTH bits, taking one
// message byte per transfer on the slave stream: tdata carries the byte, tuser says
// whether the byte belongs to the message (0 allows an empty item, for example to end
// an empty message), and tlast ends the message. The CRC of each message passes the
// input and result registers to the master stream and the engine rearms for the next
// message. One byte is taken every cycle unless a last byte waits behind a finished CRC
// not yet taken; the eight bit steps of the byte update, the optional output reversal
// and the final XOR all sit between the input register and the remainder and result
// registers, and the result register lets a new byte in while a finished CRC waits.
// Configuration writes (width, polynomial, initial value, final XOR, reflect input,
// reflect output at indexes 0 to 5) are accepted in any cycle, take effect from the
// next cycle and should be made between messages; the reset setup is CRC-32.
module parameterized_crc_engine_top #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pce_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [pce_pkg::REG_BITS-1:0]  cfg_wdata,
    // Message byte stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] byte_present
    input  logic                          s_tlast,
    // CRC result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pce_pkg::REG_BITS-1:0]  m_tdata    // [63:0] crc_value
);
    import pce_pkg::*;

    pce_cfg_t cfg;

    pce_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_out   (cfg)
    );

    pce_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
